### sv/dcpu_pkg.sv
package dcpu_pkg;

   // Operand kinds as they arrive on the request channel.
   localparam logic [3:0] KIND_REG      = 4'd0;
   localparam logic [3:0] KIND_REG_PTR  = 4'd1;
   localparam logic [3:0] KIND_NEXT_REG = 4'd2;
   localparam logic [3:0] KIND_POP      = 4'd3;
   localparam logic [3:0] KIND_PEEK     = 4'd4;
   localparam logic [3:0] KIND_PUSH     = 4'd5;
   localparam logic [3:0] KIND_SP       = 4'd6;
   localparam logic [3:0] KIND_PC       = 4'd7;
   localparam logic [3:0] KIND_O        = 4'd8;
   localparam logic [3:0] KIND_NEXT_PTR = 4'd9;

   localparam logic [3:0] OP_JSR = 4'd0;

   // Six-bit operand codes.
   localparam logic [5:0] CODE_REG_PTR  = 6'h08;
   localparam logic [5:0] CODE_NEXT_REG = 6'h10;
   localparam logic [5:0] CODE_POP      = 6'h18;
   localparam logic [5:0] CODE_PEEK     = 6'h19;
   localparam logic [5:0] CODE_PUSH     = 6'h1a;
   localparam logic [5:0] CODE_SP       = 6'h1b;
   localparam logic [5:0] CODE_PC       = 6'h1c;
   localparam logic [5:0] CODE_O        = 6'h1d;
   localparam logic [5:0] CODE_NEXT_PTR = 6'h1e;
   localparam logic [5:0] CODE_NEXT_LIT = 6'h1f;
   localparam logic [5:0] CODE_SHORT    = 6'h20;
   localparam logic [5:0] CODE_JSR_SEL  = 6'h01;

   localparam logic [15:0] SHORT_LIMIT = 16'd32;

   localparam int QUEUE_DEPTH = 2;

   // One classified instruction, ready to be serialized.
   typedef struct packed {
      logic [15:0] word;
      logic        first_has;
      logic [15:0] first_extra;
      logic        second_has;
      logic [15:0] second_extra;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic busy;
   } back_status_type;

endpackage

### sv/dcpu_front.sv
module dcpu_front (
   input  logic [3:0]          operation,
   input  logic [3:0]          first_kind,
   input  logic [2:0]          first_register,
   input  logic [15:0]         first_value,
   input  logic                first_is_label,
   input  logic [3:0]          second_kind,
   input  logic [2:0]          second_register,
   input  logic [15:0]         second_value,
   input  logic                second_is_label,
   output dcpu_pkg::entry_type entry
);

   typedef struct packed {
      logic [5:0] code;
      logic       has;
   } operand_type;

   function automatic operand_type encode(input logic [3:0] kind, input logic [2:0] regs,
                                          input logic [15:0] value, input logic is_label);
      operand_type res;
      res.has  = 1'b0;
      res.code = {3'b000, regs};
      unique case (kind)
         dcpu_pkg::KIND_REG:      res.code = {3'b000, regs};
         dcpu_pkg::KIND_REG_PTR:  res.code = dcpu_pkg::CODE_REG_PTR | {3'b000, regs};
         dcpu_pkg::KIND_NEXT_REG: begin
            res.code = dcpu_pkg::CODE_NEXT_REG | {3'b000, regs};
            res.has  = 1'b1;
         end
         dcpu_pkg::KIND_POP:      res.code = dcpu_pkg::CODE_POP;
         dcpu_pkg::KIND_PEEK:     res.code = dcpu_pkg::CODE_PEEK;
         dcpu_pkg::KIND_PUSH:     res.code = dcpu_pkg::CODE_PUSH;
         dcpu_pkg::KIND_SP:       res.code = dcpu_pkg::CODE_SP;
         dcpu_pkg::KIND_PC:       res.code = dcpu_pkg::CODE_PC;
         dcpu_pkg::KIND_O:        res.code = dcpu_pkg::CODE_O;
         dcpu_pkg::KIND_NEXT_PTR: begin
            res.code = dcpu_pkg::CODE_NEXT_PTR;
            res.has  = 1'b1;
         end
         default: begin
            // Literal, and every unused kind code is treated as one.
            if (!is_label && value < dcpu_pkg::SHORT_LIMIT) begin
               res.code = dcpu_pkg::CODE_SHORT | {1'b0, value[4:0]};
            end else begin
               res.code = dcpu_pkg::CODE_NEXT_LIT;
               res.has  = 1'b1;
            end
         end
      endcase
      return res;
   endfunction

   operand_type first_enc;
   operand_type second_enc;
   logic        is_jsr;
   logic [5:0]  first_code;

   always_comb begin
      first_enc  = encode(first_kind, first_register, first_value, first_is_label);
      second_enc = encode(second_kind, second_register, second_value, second_is_label);
      is_jsr     = (operation == dcpu_pkg::OP_JSR);
      first_code = is_jsr ? dcpu_pkg::CODE_JSR_SEL : first_enc.code;

      entry.word         = {second_enc.code, first_code, operation};
      entry.first_has    = first_enc.has && !is_jsr;
      entry.first_extra  = first_value;
      entry.second_has   = second_enc.has;
      entry.second_extra = second_value;
   end

endmodule

### sv/dcpu_queue.sv
module dcpu_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  dcpu_pkg::entry_type        push_entry,
   input  logic                       pop,
   output dcpu_pkg::entry_type        head,
   output dcpu_pkg::queue_status_type status
);

   localparam int PtrWidth = $clog2(dcpu_pkg::QUEUE_DEPTH);
   localparam int CntWidth = $clog2(dcpu_pkg::QUEUE_DEPTH + 1);

   dcpu_pkg::entry_type slots_ff [dcpu_pkg::QUEUE_DEPTH];

   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;

   function automatic logic [PtrWidth-1:0] next_ptr(input logic [PtrWidth-1:0] ptr);
      if (ptr == PtrWidth'(dcpu_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + PtrWidth'(1);
   endfunction

   always_comb begin
      status.empty = (count_ff == '0);
      status.full  = (count_ff == CntWidth'(dcpu_pkg::QUEUE_DEPTH));
      head         = slots_ff[rd_ptr_ff];

      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CntWidth'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### sv/dcpu_back.sv
module dcpu_back (
   input  logic                       clock,
   input  logic                       reset,
   input  dcpu_pkg::entry_type        head,
   input  dcpu_pkg::queue_status_type q_status,
   output logic                       pop,
   output dcpu_pkg::back_status_type  status,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [15:0]                rsp_word,
   output logic                       rsp_last
);

   typedef enum logic [2:0] {
      STEP_WORD   = 3'b001,
      STEP_FIRST  = 3'b010,
      STEP_SECOND = 3'b100
   } step_type;

   dcpu_pkg::entry_type cur_ff, cur_in;
   logic                cur_valid_ff, cur_valid_in;
   step_type            step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         rsp_word_ff, rsp_word_in;
   logic                rsp_last_ff, rsp_last_in;

   logic        emit;
   logic        done;
   step_type    step_next;
   logic [15:0] word_sel;

   always_comb begin
      word_sel  = cur_ff.word;
      step_next = STEP_WORD;
      done      = 1'b1;
      unique case (step_ff)
         STEP_WORD: begin
            word_sel = cur_ff.word;
            if (cur_ff.first_has) begin
               step_next = STEP_FIRST;
               done      = 1'b0;
            end else if (cur_ff.second_has) begin
               step_next = STEP_SECOND;
               done      = 1'b0;
            end
         end
         STEP_FIRST: begin
            word_sel = cur_ff.first_extra;
            if (cur_ff.second_has) begin
               step_next = STEP_SECOND;
               done      = 1'b0;
            end
         end
         STEP_SECOND: begin
            word_sel = cur_ff.second_extra;
         end
         default: begin
            word_sel = cur_ff.word;
         end
      endcase

      // A word moves into the output register when that register is free or drains now.
      emit = cur_valid_ff && (!rsp_valid_ff || rsp_ready);
      // The next instruction is taken as soon as the current one hands over its last word.
      pop  = !q_status.empty && (!cur_valid_ff || (emit && done));

      cur_in       = pop ? head : cur_ff;
      cur_valid_in = pop || (cur_valid_ff && !(emit && done));
      if (pop) begin
         step_in = STEP_WORD;
      end else if (emit && !done) begin
         step_in = step_next;
      end else begin
         step_in = step_ff;
      end

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
      rsp_word_in  = emit ? word_sel : rsp_word_ff;
      rsp_last_in  = emit ? done : rsp_last_ff;

      status.busy = cur_valid_ff;
      rsp_valid   = rsp_valid_ff;
      rsp_word    = rsp_word_ff;
      rsp_last    = rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff      <= STEP_WORD;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### sv/dcpu_instruction_encoder.sv
// Encoder for resolved DCPU-16 instructions.
// Request channel (req_valid/req_ready): one instruction per transfer, an
// operation plus two operand descriptors. Response channel
// (rsp_valid/rsp_ready): one 16-bit machine word per transfer; the packed
// instruction word comes first, then the first operand's extra word and then
// the second operand's, if present. rsp_last marks the final word.
// An instruction is classified as it is accepted and written into a
// two-entry queue; a serializer reads the queue and feeds a registered output.
// From idle, a request passes through a queue slot and the serializer's
// instruction register into the output register. The output register moves
// one word per cycle while rsp_ready is high; an instruction takes one word plus
// its extra words on the response channel, and that word count sets the sustained rate.
// When the receiver stalls, the output word holds, the queue fills and
// req_ready drops once both queue entries are taken.
// Synchronous reset empties the queue and the output register; no words are
// pending afterward.
module dcpu_instruction_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_operation,
   input  logic [3:0]  req_first_kind,
   input  logic [2:0]  req_first_register,
   input  logic [15:0] req_first_value,
   input  logic        req_first_is_label,
   input  logic [3:0]  req_second_kind,
   input  logic [2:0]  req_second_register,
   input  logic [15:0] req_second_value,
   input  logic        req_second_is_label,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_word,
   output logic        rsp_last
);

   dcpu_pkg::entry_type        new_entry;
   dcpu_pkg::entry_type        head;
   dcpu_pkg::queue_status_type q_status;
   dcpu_pkg::back_status_type  b_status;
   logic                       push;
   logic                       pop;

   assign req_ready = !q_status.full;
   assign push      = req_valid && req_ready;

   dcpu_front u_front (
      .operation       (req_operation),
      .first_kind      (req_first_kind),
      .first_register  (req_first_register),
      .first_value     (req_first_value),
      .first_is_label  (req_first_is_label),
      .second_kind     (req_second_kind),
      .second_register (req_second_register),
      .second_value    (req_second_value),
      .second_is_label (req_second_is_label),
      .entry           (new_entry)
   );

   dcpu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (new_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   dcpu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .status    (b_status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .rsp_last  (rsp_last)
   );

`ifndef SYNTHESIS
   // The serializer never pulls from an empty queue.
   assert property (@(posedge clock) disable iff (reset) pop |-> !q_status.empty)
      else $error("pop from empty queue");

   // An instruction accepted while everything is idle reaches the serializer next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (push && q_status.empty && !b_status.busy) |=> (pop || b_status.busy))
      else $error("accepted instruction not picked up by serializer");

   // Nothing is pending on the response channel right after reset.
   assert property (@(posedge clock) (!reset && $past(reset)) |-> !rsp_valid)
      else $error("response valid after reset");
`endif

endmodule
